@@ sv/rpfd_pkg.sv @@
`default_nettype none

package rpfd_pkg;

  // Input operations
  localparam logic [1:0] OP_RX_BYTE    = 2'd0;
  localparam logic [1:0] OP_SEND_START = 2'd1;
  localparam logic [1:0] OP_SEND_BYTE  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_RX_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_DELIVERED  = 2'd1;
  localparam logic [1:0] KIND_TX_BYTE    = 2'd2;
  localparam logic [1:0] KIND_ACK_RX     = 2'd3;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALTERNATE_ADDRESS = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DATA_TYPE_CODE    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ACK_TYPE_CODE     = 2'd3;

  // Configuration reset values
  localparam logic [7:0] RST_OWN_ADDRESS       = 8'd1;
  localparam logic [7:0] RST_ALTERNATE_ADDRESS = 8'd2;
  localparam logic [7:0] RST_DATA_TYPE_CODE    = 8'd1;
  localparam logic [7:0] RST_ACK_TYPE_CODE     = 8'd2;

  // Header byte positions (destination, source, type, sequence, length)
  localparam logic [2:0] FRM_DEST = 3'd0;
  localparam logic [2:0] FRM_SRC  = 3'd1;
  localparam logic [2:0] FRM_TYPE = 3'd2;
  localparam logic [2:0] FRM_SEQ  = 3'd3;
  localparam logic [2:0] FRM_LEN  = 3'd4;

  // Depth of the request queue between front and back
  localparam int JOBQ_DEPTH = 4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_in;
    logic       end_of_packet;
    logic [7:0] send_dest;
    logic [7:0] send_length;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       frame_end;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] alternate_address;
    logic [7:0] data_type_code;
    logic [7:0] ack_type_code;
  } cfg_t;

  // One classified request: an optional leading byte, then either a
  // transmit header or an acknowledgement frame plus delivered count.
  typedef struct packed {
    logic       lead_valid;
    logic [1:0] lead_kind;
    logic [7:0] lead_value;
    logic       lead_fend;
    logic       tx_header;
    logic       finish;
    logic [7:0] peer;
    logic [7:0] seq;
    logic [7:0] count;
  } job_t;

endpackage

`default_nettype wire

@@ sv/rpfd_front.sv @@
`default_nettype none

module rpfd_front #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rpfd_pkg::cfg_t  cfg,
  input  wire rpfd_pkg::item_t item,
  input  wire logic           accept,
  output rpfd_pkg::job_t      job,
  output logic                job_valid
);
  import rpfd_pkg::*;

  localparam logic [7:0] MaxLen = 8'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    RX_HEADER,
    RX_PAYLOAD,
    RX_DISCARD
  } rx_phase_t;

  rx_phase_t  rx_phase, rx_phase_next;
  logic [2:0] header_count, header_count_next;
  logic [7:0] payload_count, payload_count_next;
  logic [7:0] tx_sequence, tx_sequence_next;
  logic [7:0] tx_remaining, tx_remaining_next;
  logic [7:0] hdr_dest, hdr_source, hdr_kind, hdr_sequence, payload_target;
  logic [7:0] rx_len, tx_len, count_inc;
  logic       addr_ok;

  // Clamp lengths to the maximum payload
  assign rx_len    = (item.byte_in > MaxLen) ? MaxLen : item.byte_in;
  assign tx_len    = (item.send_length > MaxLen) ? MaxLen : item.send_length;
  assign count_inc = payload_count + 8'd1;
  assign addr_ok   = (hdr_dest == cfg.own_address) || (hdr_dest == cfg.alternate_address);

  // Classify the request and update receive and send state
  always_comb begin
    rx_phase_next      = rx_phase;
    header_count_next  = header_count;
    payload_count_next = payload_count;
    tx_sequence_next   = tx_sequence;
    tx_remaining_next  = tx_remaining;
    job                = '0;
    job_valid          = 1'b0;
    if (accept) begin
      case (item.op)
        OP_RX_BYTE: begin
          case (rx_phase)
            RX_HEADER: begin
              if (header_count < FRM_LEN) begin
                header_count_next = item.end_of_packet ? 3'd0 : header_count + 3'd1;
              end else begin
                header_count_next  = 3'd0;
                payload_count_next = 8'd0;
                rx_phase_next      = item.end_of_packet ? RX_HEADER : RX_DISCARD;
                if (addr_ok && hdr_kind == cfg.data_type_code) begin
                  if (rx_len == 8'd0 || item.end_of_packet) begin
                    job_valid  = 1'b1;
                    job.finish = 1'b1;
                    job.peer   = hdr_source;
                    job.seq    = hdr_sequence;
                    job.count  = 8'd0;
                  end else begin
                    rx_phase_next = RX_PAYLOAD;
                  end
                end else if (addr_ok && hdr_kind == cfg.ack_type_code) begin
                  job_valid      = 1'b1;
                  job.lead_valid = 1'b1;
                  job.lead_kind  = KIND_ACK_RX;
                  job.lead_value = hdr_sequence;
                end
              end
            end
            RX_PAYLOAD: begin
              payload_count_next = count_inc;
              job_valid          = 1'b1;
              job.lead_valid     = 1'b1;
              job.lead_kind      = KIND_RX_PAYLOAD;
              job.lead_value     = item.byte_in;
              if (count_inc >= payload_target || item.end_of_packet) begin
                job.finish    = 1'b1;
                job.peer      = hdr_source;
                job.seq       = hdr_sequence;
                job.count     = count_inc;
                rx_phase_next = item.end_of_packet ? RX_HEADER : RX_DISCARD;
              end
            end
            default: begin
              if (item.end_of_packet) rx_phase_next = RX_HEADER;
            end
          endcase
        end
        OP_SEND_START: begin
          job_valid         = 1'b1;
          job.tx_header     = 1'b1;
          job.peer          = item.send_dest;
          job.seq           = tx_sequence;
          job.count         = tx_len;
          tx_sequence_next  = tx_sequence + 8'd1;
          tx_remaining_next = tx_len;
        end
        OP_SEND_BYTE: begin
          if (tx_remaining != 8'd0) begin
            tx_remaining_next = tx_remaining - 8'd1;
            job_valid         = 1'b1;
            job.lead_valid    = 1'b1;
            job.lead_kind     = KIND_TX_BYTE;
            job.lead_value    = item.byte_in;
            job.lead_fend     = (tx_remaining == 8'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_phase      <= RX_HEADER;
      header_count  <= 3'd0;
      payload_count <= 8'd0;
      tx_sequence   <= 8'd0;
      tx_remaining  <= 8'd0;
    end else begin
      rx_phase      <= rx_phase_next;
      header_count  <= header_count_next;
      payload_count <= payload_count_next;
      tx_sequence   <= tx_sequence_next;
      tx_remaining  <= tx_remaining_next;
    end
  end

  // Capture header fields
  always_ff @(posedge clk) begin
    if (accept && item.op == OP_RX_BYTE && rx_phase == RX_HEADER) begin
      case (header_count)
        FRM_DEST: hdr_dest       <= item.byte_in;
        FRM_SRC:  hdr_source     <= item.byte_in;
        FRM_TYPE: hdr_kind       <= item.byte_in;
        FRM_SEQ:  hdr_sequence   <= item.byte_in;
        default:  payload_target <= rx_len;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/rpfd_jobq.sv @@
`default_nettype none

module rpfd_jobq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire rpfd_pkg::job_t job_in,
  output logic               full,
  input  wire logic          deq,
  output logic               empty,
  output rpfd_pkg::job_t     head
);
  import rpfd_pkg::*;

  localparam int PtrW = $clog2(JOBQ_DEPTH);
  localparam int CntW = $clog2(JOBQ_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(JOBQ_DEPTH - 1);

  job_t            slots [JOBQ_DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push, do_deq;

  assign full    = (fill == CntW'(JOBQ_DEPTH));
  assign empty   = (fill == '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_deq  = deq && !empty;

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (do_deq)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_deq) fill <= fill + 1'b1;
      else if (!do_push && do_deq) fill <= fill - 1'b1;
    end
  end

  // Store requests
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= job_in;
  end

endmodule

`default_nettype wire

@@ sv/rpfd_back.sv @@
`default_nettype none

module rpfd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rpfd_pkg::cfg_t cfg,
  input  wire rpfd_pkg::job_t head,
  input  wire logic          head_empty,
  output logic               deq,
  output rpfd_pkg::result_t  result,
  output logic               empty,
  input  wire logic          pop
);
  import rpfd_pkg::*;

  logic [2:0] idx, n_total, f_idx;
  logic       out_valid, advance, last;
  result_t    res;

  assign n_total = {2'b00, head.lead_valid} + (head.tx_header ? 3'd5 : 3'd0)
                 + (head.finish ? 3'd6 : 3'd0);
  assign f_idx   = idx - {2'b00, head.lead_valid};
  assign last    = (idx == n_total - 3'd1);
  assign advance = !out_valid || pop;
  assign deq     = advance && !head_empty && last;
  assign empty   = !out_valid;

  // Pick the result for the current step of the request
  always_comb begin
    res             = '0;
    res.last_of_run = last;
    if (head.lead_valid && idx == 3'd0) begin
      res.kind      = head.lead_kind;
      res.value     = head.lead_value;
      res.frame_end = head.lead_fend;
    end else begin
      res.kind = KIND_TX_BYTE;
      case (f_idx)
        FRM_DEST: res.value = head.peer;
        FRM_SRC:  res.value = cfg.own_address;
        FRM_TYPE: res.value = head.finish ? cfg.ack_type_code : cfg.data_type_code;
        FRM_SEQ:  res.value = head.seq;
        FRM_LEN: begin
          res.value     = head.finish ? 8'd0 : head.count;
          res.frame_end = head.finish || (head.count == 8'd0);
        end
        default: begin
          res.kind  = KIND_DELIVERED;
          res.value = head.count;
        end
      endcase
    end
  end

  // Advance the step counter and load the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 3'd0;
      out_valid <= 1'b0;
    end else if (advance) begin
      if (!head_empty) begin
        out_valid <= 1'b1;
        idx       <= last ? 3'd0 : idx + 3'd1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && !head_empty) result <= res;
  end

endmodule

`default_nettype wire

@@ sv/radio_packet_framer_deframer.sv @@
// Radio frame framer/deframer with a queue-style interface on both sides.
// Requests: drive item and raise push; a request is taken at a clock edge
// where push is high and full is low. Results: while empty is low the oldest
// result sits on result; raise pop to take it. Configuration: cfg_index and
// cfg_data with cfg_valid; cfg_ready is always high, write only while idle.
// Receive bytes (op 0) are deframed; a start (op 1) emits a five-byte header;
// send bytes (op 2) pass through up to the clamped length.
// The front classifies each request in the cycle it is taken and places a
// descriptor in a four-entry queue; the back expands it into 1 to 7 results,
// one per cycle while the receiver does not stall, into an output register.
// The first result of a request passes through the queue and the output
// register. A request yields 1 to 7 results, none for dropped bytes.
// Requests are taken every cycle while the queue has room, also while the
// back is still expanding earlier descriptors.
// Reset clears the queue, the output register, receive/send state and loads
// the default configuration. When the receiver stalls, results hold, the
// queue fills and full rises after four waiting descriptors.
`default_nettype none

module radio_packet_framer_deframer #(
  parameter int MAX_PAYLOAD = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 push,
  output logic                                      full,
  input  wire rpfd_pkg::item_t                       item,
  output logic                                      empty,
  input  wire logic                                 pop,
  output rpfd_pkg::result_t                         result,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [rpfd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [7:0]                           cfg_data
);
  import rpfd_pkg::*;

  cfg_t cfg;
  job_t job, head;
  logic job_valid, accept, head_empty, deq;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_address       <= RST_OWN_ADDRESS;
      cfg.alternate_address <= RST_ALTERNATE_ADDRESS;
      cfg.data_type_code    <= RST_DATA_TYPE_CODE;
      cfg.ack_type_code     <= RST_ACK_TYPE_CODE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OWN_ADDRESS:       cfg.own_address       <= cfg_data;
        REG_ALTERNATE_ADDRESS: cfg.alternate_address <= cfg_data;
        REG_DATA_TYPE_CODE:    cfg.data_type_code    <= cfg_data;
        REG_ACK_TYPE_CODE:     cfg.ack_type_code     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rpfd_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .accept    (accept),
    .job       (job),
    .job_valid (job_valid)
  );

  rpfd_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .push   (job_valid),
    .job_in (job),
    .full   (full),
    .deq    (deq),
    .empty  (head_empty),
    .head   (head)
  );

  rpfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_empty (head_empty),
    .deq        (deq),
    .result     (result),
    .empty      (empty),
    .pop        (pop)
  );

  // Nothing is pending right after reset
  a_reset_idle: assert property (@(posedge clk) (!rst && $past(rst)) |-> (empty && !full))
    else $error("result or request queue not idle after reset");

  // Only transmitted bytes close a frame
  a_fend_tx_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.kind != KIND_TX_BYTE) |-> !result.frame_end)
    else $error("frame_end on a non-transmit result");

  // Delivered counts and ack reports always end their request's run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.kind == KIND_DELIVERED || result.kind == KIND_ACK_RX))
      |-> result.last_of_run)
    else $error("count or ack report not last of its run");

endmodule

`default_nettype wire

@@ bench/tb_radio_packet_framer_deframer.sv @@
`default_nettype none

module tb_radio_packet_framer_deframer;
  import rpfd_pkg::*;

  localparam int MAX_LEN      = 64;
  localparam int DRAIN_CYCLES = 24;
  localparam int LONG_HOLD    = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_HEADER, RX_PAYLOAD, RX_DISCARD} rx_phase_e;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   push = 1'b0;
  logic                   full;
  item_t                  item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_OWN_ADDRESS;
  logic [7:0]             cfg_data = 8'd0;

  // Requests waiting to be offered, results still owed by the block
  item_t   backlog[$];
  result_t owed_results[$];
  result_t run_buf[$];
  int      items_made = 0;
  int      errors = 0;
  bit      calm = 1'b0;

  // Mirror of the block's configuration and frame state
  cfg_t       cfg_copy = '{RST_OWN_ADDRESS, RST_ALTERNATE_ADDRESS,
                           RST_DATA_TYPE_CODE, RST_ACK_TYPE_CODE};
  rx_phase_e  rx_phase = RX_HEADER;
  logic [2:0] hdr_count = 3'd0;
  logic [7:0] hdr_dest = 8'd0, hdr_source = 8'd0, hdr_kind = 8'd0, hdr_seq = 8'd0;
  logic [7:0] pay_target = 8'd0, pay_count = 8'd0;
  logic [7:0] tx_seq = 8'd0, tx_left = 8'd0;

  radio_packet_framer_deframer #(.MAX_PAYLOAD(MAX_LEN)) u_top (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [7:0] clamp_len(input logic [7:0] l);
    return (l > MAX_LEN) ? 8'(MAX_LEN) : l;
  endfunction

  function automatic void emit(input logic [1:0] k, input logic [7:0] v, input logic fe);
    result_t r;
    r.kind = k;
    r.value = v;
    r.frame_end = fe;
    r.last_of_run = 1'b0;
    run_buf.push_back(r);
  endfunction

  // Acknowledge the frame just received, then report how much was delivered
  function automatic void ack_and_count();
    emit(KIND_TX_BYTE, hdr_source, 1'b0);
    emit(KIND_TX_BYTE, cfg_copy.own_address, 1'b0);
    emit(KIND_TX_BYTE, cfg_copy.ack_type_code, 1'b0);
    emit(KIND_TX_BYTE, hdr_seq, 1'b0);
    emit(KIND_TX_BYTE, 8'd0, 1'b1);
    emit(KIND_DELIVERED, pay_count, 1'b0);
  endfunction

  function automatic void take_rx_byte(input logic [7:0] b, input logic eop);
    case (rx_phase)
      RX_HEADER: begin
        case (hdr_count)
          FRM_DEST: hdr_dest = b;
          FRM_SRC:  hdr_source = b;
          FRM_TYPE: hdr_kind = b;
          FRM_SEQ:  hdr_seq = b;
          default:  pay_target = clamp_len(b);
        endcase
        if (hdr_count < FRM_LEN) begin
          hdr_count = eop ? 3'd0 : hdr_count + 3'd1;
        end else begin
          hdr_count = 3'd0;
          pay_count = 8'd0;
          if (hdr_dest != cfg_copy.own_address && hdr_dest != cfg_copy.alternate_address) begin
            rx_phase = eop ? RX_HEADER : RX_DISCARD;
          end else if (hdr_kind == cfg_copy.data_type_code) begin
            if (pay_target == 8'd0 || eop) begin
              ack_and_count();
              rx_phase = eop ? RX_HEADER : RX_DISCARD;
            end else begin
              rx_phase = RX_PAYLOAD;
            end
          end else if (hdr_kind == cfg_copy.ack_type_code) begin
            emit(KIND_ACK_RX, hdr_seq, 1'b0);
            rx_phase = eop ? RX_HEADER : RX_DISCARD;
          end else begin
            rx_phase = eop ? RX_HEADER : RX_DISCARD;
          end
        end
      end
      RX_PAYLOAD: begin
        emit(KIND_RX_PAYLOAD, b, 1'b0);
        pay_count = pay_count + 8'd1;
        if (pay_count >= pay_target || eop) begin
          ack_and_count();
          rx_phase = eop ? RX_HEADER : RX_DISCARD;
        end
      end
      default: begin
        if (eop) rx_phase = RX_HEADER;
      end
    endcase
  endfunction

  // Work out the results of one accepted request and queue them as owed
  function automatic void compute_outputs(input item_t it);
    logic [7:0] len;
    result_t    r;
    run_buf.delete();
    case (it.op)
      OP_RX_BYTE: take_rx_byte(it.byte_in, it.end_of_packet);
      OP_SEND_START: begin
        len = clamp_len(it.send_length);
        emit(KIND_TX_BYTE, it.send_dest, 1'b0);
        emit(KIND_TX_BYTE, cfg_copy.own_address, 1'b0);
        emit(KIND_TX_BYTE, cfg_copy.data_type_code, 1'b0);
        emit(KIND_TX_BYTE, tx_seq, 1'b0);
        emit(KIND_TX_BYTE, len, len == 8'd0);
        tx_seq = tx_seq + 8'd1;
        tx_left = len;
      end
      OP_SEND_BYTE: begin
        if (tx_left > 8'd0) begin
          tx_left = tx_left - 8'd1;
          emit(KIND_TX_BYTE, it.byte_in, tx_left == 8'd0);
        end
      end
      default: ;
    endcase
    if (run_buf.size() > 0) begin
      r = run_buf.pop_back();
      r.last_of_run = 1'b1;
      run_buf.push_back(r);
    end
    foreach (run_buf[i]) owed_results.push_back(run_buf[i]);
  endfunction

  // Mostly short gaps, now and then a long one; none in calm phases
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_item(input logic [1:0] op, input logic [7:0] b, input logic eop,
                          input logic [7:0] dest, input logic [7:0] len);
    item_t it;
    it.op = op;
    it.byte_in = b;
    it.end_of_packet = eop;
    it.send_dest = dest;
    it.send_length = len;
    backlog.push_back(it);
    if (op != OP_UNUSED) items_made++;
  endtask

  // Queue one received packet: header, npay payload bytes, end flag on the last
  task automatic rx_frame(input logic [7:0] dest, input logic [7:0] kind,
                          input logic [7:0] seq, input logic [7:0] len, input int npay);
    logic [7:0] hdr[5];
    logic [7:0] b;
    hdr = '{dest, 8'($urandom), kind, seq, len};
    for (int i = 0; i < 5 + npay; i++) begin
      b = (i < 5) ? hdr[i] : 8'($urandom);
      add_item(OP_RX_BYTE, b, i == 4 + npay, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic send_frame(input logic [7:0] dest, input logic [7:0] len, input int npay);
    add_item(OP_SEND_START, 8'($urandom), 1'($urandom), dest, len);
    repeat (npay) add_item(OP_SEND_BYTE, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic int pick_count(input int c);
    int m;
    m = $urandom_range(0, 5);
    if (m < 3) return c;
    if (m == 3) return $urandom_range(0, c);
    return c + $urandom_range(1, 3);
  endfunction

  task automatic random_scenario();
    int         r, n;
    logic [7:0] d, t, l;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      // received packet with a full header, mostly to us and of a known type
      n = $urandom_range(0, 9);
      d = (n < 4) ? cfg_copy.own_address : (n < 8) ? cfg_copy.alternate_address : 8'($urandom);
      n = $urandom_range(0, 9);
      t = (n < 5) ? cfg_copy.data_type_code : (n < 8) ? cfg_copy.ack_type_code : 8'($urandom);
      l = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      rx_frame(d, t, 8'($urandom), l, pick_count(clamp_len(l)));
    end else if (r < 65) begin
      l = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
      send_frame(8'($urandom), l, pick_count(clamp_len(l)));
    end else if (r < 72) begin
      // short header
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
        add_item(OP_RX_BYTE, 8'($urandom), i == n - 1, 8'($urandom), 8'($urandom));
    end else if (r < 80) begin
      // receive a data frame while a send is owed payload
      l = 8'($urandom_range(1, 3));
      add_item(OP_SEND_START, 8'($urandom), 1'($urandom), 8'($urandom), l);
      rx_frame(cfg_copy.own_address, cfg_copy.data_type_code, 8'($urandom), 8'd1, 1);
      repeat (l) add_item(OP_SEND_BYTE, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    end else if (r < 92) begin
      // noise, then an end-of-packet byte to resync the header collector
      n = $urandom_range(1, 4);
      repeat (n) add_item(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
                          8'($urandom), 8'($urandom));
      add_item(OP_RX_BYTE, 8'($urandom), 1'b1, 8'($urandom), 8'($urandom));
    end else begin
      add_item(OP_UNUSED, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Write one register; valid stays high so set_config writes all four back to back
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input cfg_t c);
    write_reg(REG_OWN_ADDRESS, c.own_address);
    write_reg(REG_ALTERNATE_ADDRESS, c.alternate_address);
    write_reg(REG_DATA_TYPE_CODE, c.data_type_code);
    write_reg(REG_ACK_TYPE_CODE, c.ack_type_code);
    cfg_valid <= 1'b0;
    cfg_copy = c;
  endtask

  task automatic wait_idle();
    while (backlog.size() != 0 || push || owed_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Request driver: offer backlog items with random gaps, hold while full
  always @(posedge clk) begin : request_driver
    int tx_gap;
    if (!rst) begin
      if (push && !full) begin
        compute_outputs(item);
        tx_gap = rand_gap();
      end
      if (!push || !full) begin
        if (tx_gap > 0) begin
          tx_gap--;
          push <= 1'b0;
        end else if (backlog.size() != 0) begin
          item <= backlog.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each popped result, stall at random and long after results 50 and 800
  always @(posedge clk) begin : result_monitor
    int      stall_left;
    int      taken;
    result_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          $error("result with nothing owed: kind %0d value %0d", result.kind, result.value);
          errors++;
        end else begin
          want = owed_results.pop_front();
          if (result.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, result.kind);
            errors++;
          end
          if (result.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, result.value);
            errors++;
          end
          if (result.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0d, got %0d", want.frame_end, result.frame_end);
            errors++;
          end
          if (result.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", want.last_of_run, result.last_of_run);
            errors++;
          end
        end
        taken++;
        stall_left = (taken == 50 || taken == 800) ? LONG_HOLD : rand_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Sequence: reset, directed checks, then phases over several register settings
  initial begin : stimulus
    cfg_t plan[5];
    int   target;
    plan[0] = '{RST_OWN_ADDRESS, RST_ALTERNATE_ADDRESS, RST_DATA_TYPE_CODE, RST_ACK_TYPE_CODE};
    plan[1] = '{8'h00, 8'h00, 8'h00, 8'h00};
    plan[2] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    plan[3] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    plan[4].own_address = 8'($urandom);
    plan[4].alternate_address = 8'($urandom);
    plan[4].data_type_code = 8'($urandom);
    plan[4].ack_type_code = plan[4].data_type_code ^ 8'h01;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero-length send, clamped send, restart, surplus payload
    add_item(OP_SEND_START, 8'h00, 1'b0, 8'h00, 8'h00);
    add_item(OP_SEND_START, 8'h00, 1'b0, 8'hFF, 8'hFF);
    add_item(OP_SEND_BYTE, 8'hFF, 1'b1, 8'h00, 8'h00);
    add_item(OP_SEND_START, 8'hFF, 1'b1, 8'hAA, 8'h01);
    add_item(OP_SEND_BYTE, 8'h00, 1'b0, 8'hFF, 8'hFF);
    add_item(OP_SEND_BYTE, 8'h5A, 1'b0, 8'h00, 8'h00);
    // short header, zero-length data with trailing byte, ack, early packet end
    add_item(OP_RX_BYTE, 8'h01, 1'b0, 8'h00, 8'h00);
    add_item(OP_RX_BYTE, 8'h02, 1'b1, 8'hFF, 8'hFF);
    rx_frame(RST_OWN_ADDRESS, RST_DATA_TYPE_CODE, 8'hFF, 8'h00, 1);
    rx_frame(RST_ALTERNATE_ADDRESS, RST_ACK_TYPE_CODE, 8'h00, 8'h00, 0);
    rx_frame(RST_OWN_ADDRESS, RST_DATA_TYPE_CODE, 8'h07, 8'h02, 1);
    add_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 8'hFF);

    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_idle();
        @(posedge clk);
        set_config(plan[p]);
        @(negedge clk);
      end
      calm = (p == 2) || ($urandom_range(0, 3) == 0);
      target = (p == 0) ? 100 : items_made + 95;
      while (items_made < target) random_scenario();
    end

    wait_idle();
    if (errors == 0 && owed_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
sv/rpfd_pkg.sv
sv/rpfd_front.sv
sv/rpfd_jobq.sv
sv/rpfd_back.sv
sv/radio_packet_framer_deframer.sv
bench/tb_radio_packet_framer_deframer.sv
